// ===== rtl/golomb_code_bit_packer_top_macros.svh =====
// ----------------------------------------------------------------------------
// golomb code bit packer assertion macros
// shared concurrent assertion forms on clk with asynchronous reset rst_n
// ----------------------------------------------------------------------------
`ifndef GOLOMB_CODE_BIT_PACKER_TOP_MACROS_SVH
`define GOLOMB_CODE_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication
`define GCBP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcbp assertion failed");

// next-cycle implication
`define GCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcbp assertion failed");

`endif

// ===== rtl/gcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcbp_pkg
// shared constants and types of the golomb code bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcbp_pkg;

    localparam int MAX_BINARY_BITS = 32;
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef struct packed {
        logic [7:0] partial;
        logic [2:0] filled;
        logic [7:0] chunk;
        logic [3:0] take;
    } merge_req_t;

    typedef struct packed {
        logic [7:0] merged;
        logic [3:0] fill_count;
        logic       full;
    } merge_rsp_t;

endpackage

// ===== rtl/gcbp_merge_unit.sv =====
// ----------------------------------------------------------------------------
// gcbp_merge_unit
// shared shift unit: places the top bits of a chunk behind the pending bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcbp_merge_unit
(
    input  gcbp_pkg::merge_req_t req,
    output gcbp_pkg::merge_rsp_t rsp
);

    logic [7:0] keep_mask;
    logic [7:0] chunk_kept;

    always_comb
    begin
        keep_mask       = ~(8'hFF >> req.take);
        chunk_kept      = req.chunk & keep_mask;
        rsp.merged      = req.partial | (chunk_kept >> req.filled);
        rsp.fill_count  = {1'b0, req.filled} + req.take;
        rsp.full        = rsp.fill_count[3];
    end

endmodule

// ===== rtl/golomb_code_bit_packer_top.sv =====
// ----------------------------------------------------------------------------
// golomb_code_bit_packer_top
// packs golomb codewords into an msb-first byte stream
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready with mode, binary_value, binary_length
// and unary_length. an encode transfer appends the low binary_length bits
// (saturated to 32), then unary_length - 1 zeros and a one. a flush transfer
// emits the pending partial byte, zero padded, and clears the state.
// output channel: out_valid / out_ready with out_byte and last; last marks
// the final byte caused by one input transfer.
// one sequencer step merges up to 8 - pending bits of one segment through a
// single shared shift unit, one step per cycle while the output is not
// stalled. a nonempty segment takes ceil((pending + its bits) / 8) steps, so
// an encode takes between ceil(binary bits / 8) + ceil(unary bits / 8) steps
// and two more, after the idle state accepts it; a flush with bits pending
// passes through the flush state, without them it stays idle. in_ready is
// high only while idle. a byte is presented in the cycle after the step that
// completes it. a stalled receiver holds the output register and freezes
// the sequencer. reset clears the pending bits, last and out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "golomb_code_bit_packer_top_macros.svh"

module golomb_code_bit_packer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] binary_value,
    input  logic [5:0]  binary_length,
    input  logic [7:0]  unary_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

    state_t      state_reg, state_next;
    logic [31:0] value_reg, value_next;
    logic [5:0]  brem_reg, brem_next;
    logic [7:0]  urem_reg, urem_next;
    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  filled_reg, filled_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg, last_next;

    logic        step_en;
    logic        in_xfer;
    logic [5:0]  blen_sat;
    logic [3:0]  space;
    logic        is_bin;
    logic [7:0]  seg_rem;
    logic [3:0]  take;
    logic [7:0]  unary_chunk;
    logic [8:0]  rem_after;
    logic        byte_done;
    logic        byte_step;

    gcbp_pkg::merge_req_t merge_req;
    gcbp_pkg::merge_rsp_t merge_rsp;

    gcbp_merge_unit u_merge
    (
        .req (merge_req),
        .rsp (merge_rsp)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign step_en   = !(out_valid_reg && !out_ready);
    assign byte_step = (state_reg == ST_RUN) && step_en && byte_done;

    always_comb
    begin
        blen_sat = (binary_length > 6'(gcbp_pkg::MAX_BINARY_BITS))
                   ? 6'(gcbp_pkg::MAX_BINARY_BITS) : binary_length;
        space    = 4'd8 - {1'b0, filled_reg};
        is_bin   = (brem_reg != 6'd0);
        seg_rem  = is_bin ? {2'b00, brem_reg} : urem_reg;
        take     = (seg_rem < {4'b0000, space}) ? seg_rem[3:0] : space;
        unary_chunk = ({4'b0000, take} == urem_reg) ? (8'h80 >> (take - 4'd1)) : 8'h00;
        rem_after = {3'b000, brem_reg} + {1'b0, urem_reg} - {5'b00000, take};

        merge_req.partial = partial_reg;
        merge_req.filled  = filled_reg;
        merge_req.chunk   = is_bin ? value_reg[31:24] : unary_chunk;
        merge_req.take    = take;
        byte_done         = merge_rsp.full;
    end

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        brem_next      = brem_reg;
        urem_next      = urem_reg;
        partial_next   = partial_reg;
        filled_next    = filled_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (mode == gcbp_pkg::MODE_FLUSH)
                    begin
                        if (filled_reg != 3'd0)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        value_next = binary_value << (6'd32 - blen_sat);
                        brem_next  = blen_sat;
                        urem_next  = unary_length;
                        if ((blen_sat != 6'd0) || (unary_length != 8'd0))
                        begin
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (step_en)
                begin
                    if (is_bin)
                    begin
                        value_next = value_reg << take;
                        brem_next  = brem_reg - {2'b00, take};
                    end
                    else
                    begin
                        urem_next = urem_reg - {4'b0000, take};
                    end
                    if (byte_done)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = merge_rsp.merged;
                        last_next      = (rem_after < 9'd8);
                        partial_next   = 8'h00;
                        filled_next    = 3'd0;
                    end
                    else
                    begin
                        partial_next = merge_rsp.merged;
                        filled_next  = merge_rsp.fill_count[2:0];
                    end
                    if (rem_after == 9'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (step_en)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = partial_reg;
                    last_next      = 1'b1;
                    partial_next   = 8'h00;
                    filled_next    = 3'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            brem_reg      <= 6'd0;
            urem_reg      <= 8'd0;
            partial_reg   <= 8'h00;
            filled_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            brem_reg      <= brem_next;
            urem_reg      <= urem_next;
            partial_reg   <= partial_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        out_byte_reg <= out_byte_next;
    end

    // flush state is entered only with bits pending
    `GCBP_ASSERT_IMPL(a_flush_has_bits, state_reg == ST_FLUSH, filled_reg != 3'd0)
    // the sequencer runs only while bits of the item remain
    `GCBP_ASSERT_IMPL(a_run_has_work, state_reg == ST_RUN, is_bin || (urem_reg != 8'd0))
    // a byte that is not the last keeps the item running
    `GCBP_ASSERT_NEXT(a_not_last_keeps_run, byte_step && (rem_after >= 9'd8), state_reg == ST_RUN)

endmodule

// ===== tb/sv/tb_golomb_code_bit_packer_top.sv =====
// ----------------------------------------------------------------------------
// tb_golomb_code_bit_packer_top
// self-checking bench for the golomb code bit packer: a short directed table
// (extremes, masking, saturation, flushes with and without pending bits) is
// followed by random codewords and flushes under four idling phases; every
// output byte is checked against a typed byte or bit-level packing predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_golomb_code_bit_packer_top;

    localparam int MAX_UNARY_BITS = 255;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic        mode;
        logic [31:0] value;
        logic [5:0]  blen;
        logic [7:0]  ulen;
        logic        typed;
        logic [1:0]  n_typed;
        logic [7:0]  typed_byte;
    } code_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = gcbp_pkg::MODE_ENCODE;
    logic [31:0] binary_value = '0;
    logic [5:0]  binary_length = '0;
    logic [7:0]  unary_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last;

    // predictor state
    logic [7:0] acc_bits = '0;
    int         acc_fill = 0;
    logic [7:0] step_bytes[$];

    // expected output stream
    logic [7:0] byte_stream_q[$];
    bit         last_flag_q[$];

    code_row_t  dir_rows[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         errors = 0;
    int         items_sent = 0;
    int         flushes_sent = 0;
    int         bytes_checked = 0;
    int         quiet_cycles = 0;

    golomb_code_bit_packer_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .binary_value  (binary_value),
        .binary_length (binary_length),
        .unary_length  (unary_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task report_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function void shift_in(input logic b);
        if (b)
        begin
            acc_bits[7 - acc_fill] = 1'b1;
        end
        acc_fill++;
        if (acc_fill == 8)
        begin
            step_bytes.push_back(acc_bits);
            acc_bits = '0;
            acc_fill = 0;
        end
    endfunction

    function void pack_codeword(input logic md, input logic [31:0] val,
                                input logic [5:0] blen, input logic [7:0] ulen);
        int nb;
        int nu;
        step_bytes.delete();
        if (md == gcbp_pkg::MODE_FLUSH)
        begin
            if (acc_fill != 0)
            begin
                step_bytes.push_back(acc_bits);
            end
            acc_bits = '0;
            acc_fill = 0;
        end
        else
        begin
            nb = (blen > gcbp_pkg::MAX_BINARY_BITS) ? gcbp_pkg::MAX_BINARY_BITS : int'(blen);
            nu = (ulen > MAX_UNARY_BITS) ? MAX_UNARY_BITS : int'(ulen);
            for (int i = nb - 1; i >= 0; i--)
            begin
                shift_in(val[i]);
            end
            if (nu > 0)
            begin
                for (int i = 1; i < nu; i++)
                begin
                    shift_in(1'b0);
                end
                shift_in(1'b1);
            end
        end
    endfunction

    task automatic send_item(input code_row_t row);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        mode          <= row.mode;
        binary_value  <= row.value;
        binary_length <= row.blen;
        unary_length  <= row.ulen;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pack_codeword(row.mode, row.value, row.blen, row.ulen);
        if (row.typed)
        begin
            for (int i = 0; i < row.n_typed; i++)
            begin
                byte_stream_q.push_back(row.typed_byte);
                last_flag_q.push_back(i == row.n_typed - 1);
            end
        end
        else
        begin
            for (int i = 0; i < step_bytes.size(); i++)
            begin
                byte_stream_q.push_back(step_bytes[i]);
                last_flag_q.push_back(i == step_bytes.size() - 1);
            end
        end
        items_sent++;
        if (row.mode == gcbp_pkg::MODE_FLUSH)
        begin
            flushes_sent++;
        end
    endtask

    // hold off new transfers until the output stream has fully drained
    task drain_stream;
        in_valid <= 1'b0;
        while (byte_stream_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function code_row_t random_row;
        code_row_t r;
        int sel;
        r = '0;
        r.mode = ($urandom_range(99) < 12) ? gcbp_pkg::MODE_FLUSH : gcbp_pkg::MODE_ENCODE;
        r.value = $urandom;
        sel = $urandom_range(99);
        if (sel < 70)
            r.blen = 6'($urandom_range(0, 16));
        else if (sel < 90)
            r.blen = 6'($urandom_range(17, 32));
        else
            r.blen = 6'($urandom_range(33, 63));
        sel = $urandom_range(99);
        if (sel < 70)
            r.ulen = 8'($urandom_range(0, 10));
        else if (sel < 92)
            r.ulen = 8'($urandom_range(11, 40));
        else
            r.ulen = 8'($urandom_range(41, 255));
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (byte_stream_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last));
            end
            else
            begin
                if (out_byte !== byte_stream_q[0])
                begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, byte_stream_q[0]));
                end
                if (last !== last_flag_q[0])
                begin
                    report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                              last, last_flag_q[0], byte_stream_q[0]));
                end
                void'(byte_stream_q.pop_front());
                void'(last_flag_q.pop_front());
                bytes_checked++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // mode, value, binary length, unary length, typed, count, byte
        dir_rows.push_back({gcbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0,  8'd0,
                            1'b1, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'hFFFF_FFA5, 6'd8,  8'd0,
                            1'b1, 2'd1, 8'hA5});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h0000_0000, 6'd0,  8'd8,
                            1'b1, 2'd1, 8'h01});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'hFFFF_FFFF, 6'd0,  8'd0,
                            1'b1, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h0000_0005, 6'd3,  8'd0,
                            1'b1, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_FLUSH,  32'hFFFF_FFFF, 6'd63, 8'd255,
                            1'b1, 2'd1, 8'hA0});
        dir_rows.push_back({gcbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0,  8'd0,
                            1'b1, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'hFFFF_FFFF, 6'd32, 8'd0,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h1234_5678, 6'd63, 8'd1,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h8000_0001, 6'd40, 8'd255,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h0000_0000, 6'd32, 8'd255,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'hFFFF_FFFF, 6'd7,  8'd0,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h0000_0000, 6'd1,  8'd0,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'hAAAA_AAAA, 6'd33, 8'd2,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h0000_0000, 6'd0,  8'd1,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_FLUSH,  32'h5555_5555, 6'd21, 8'd3,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'hDEAD_BEEF, 6'd16, 8'd200,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_ENCODE, 32'h7FFF_FFFE, 6'd31, 8'd0,
                            1'b0, 2'd0, 8'h00});
        dir_rows.push_back({gcbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0,  8'd0,
                            1'b0, 2'd0, 8'h00});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i]);
        end
        drain_stream();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_item(random_row());
            end
            drain_stream();
        end

        in_valid <= 1'b0;
        while (byte_stream_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d input transfers (%0d flushes), %0d output bytes checked",
                 items_sent, flushes_sent, bytes_checked);
        $display("idling phases: none, sender 80%%, receiver 80%%, both 27%%; %0d errors",
                 errors);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== golomb_code_bit_packer_top.f =====
+incdir+rtl
rtl/gcbp_pkg.sv
rtl/gcbp_merge_unit.sv
rtl/golomb_code_bit_packer_top.sv
tb/sv/tb_golomb_code_bit_packer_top.sv
